// ===== hdl/dali_pkg.sv =====
// shared types and constants for the backward frame manchester decoder
// no dependencies
package dali_pkg;

  localparam int MAX_EDGES  = 20;
  localparam int FRAME_BITS = 9;

  localparam int TIME_W     = 24;
  localparam int DUR_W      = 16;
  localparam int REG_W      = 12;
  localparam int GAP_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int EDGE_W     = $clog2(MAX_EDGES + 1);
  localparam int BP_W       = $clog2(FRAME_BITS + 1);
  localparam int IDX_W      = $clog2(FRAME_BITS);

  localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};
  localparam logic [REG_W-1:0]  PERIOD_RST    = 12'd833;
  localparam logic [REG_W-1:0]  OFFSET_RST    = 12'd416;
  localparam logic [REG_W-1:0]  TOL_RST       = 12'd150;
  localparam logic [GAP_W-1:0]  GAP_RST       = 16'd2000;
  localparam logic [BYTE_W-1:0] FAIL_BYTE     = {BYTE_W{1'b1}};

  typedef enum logic [1:0] {
    DIR_NONE,
    DIR_FALL,
    DIR_RISE
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_PERIOD,
    CFG_MID_OFFSET,
    CFG_MID_TOLERANCE,
    CFG_START_GAP
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_CLOSE,
    ST_MID,
    ST_TIME,
    ST_FLUSH,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic load_in;
    logic edge_start;
    logic close_win;
    logic mid_take;
    logic time_add;
    logic flush_win;
    logic final_load;
  } cmd_t;

  typedef struct packed {
    logic take_edge;
    logic can_close;
    logic can_flush;
    logic last;
    logic frame_ok;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/dali_ctrl.sv =====
// sequencing state machine for the decoder
// depends on dali_pkg
module dali_ctrl import dali_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd,
  output state_t  state
);

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EDGE;
      end
      ST_EDGE: begin
        state_next = status.take_edge ? ST_CLOSE : ST_TIME;
      end
      ST_CLOSE: begin
        if (!status.can_close) state_next = ST_MID;
      end
      ST_MID: begin
        state_next = ST_TIME;
      end
      ST_TIME: begin
        if (!status.last) state_next = ST_IDLE;
        else if (status.frame_ok) state_next = ST_FLUSH;
        else state_next = ST_FINAL;
      end
      ST_FLUSH: begin
        if (!status.can_flush) state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    cmd            = '0;
    cmd.load_in    = (state == ST_IDLE) && in_valid;
    cmd.edge_start = (state == ST_EDGE) && status.take_edge;
    cmd.close_win  = (state == ST_CLOSE) && status.can_close;
    cmd.mid_take   = (state == ST_MID);
    cmd.time_add   = (state == ST_TIME);
    cmd.flush_win  = (state == ST_FLUSH) && status.can_flush;
    cmd.final_load = (state == ST_FINAL) && status.out_free;
  end

endmodule

// ===== hdl/dali_dp.sv =====
// decoder datapath: settings, timing, edge and window logic, result register
// depends on dali_pkg
module dali_dp import dali_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  pulse_level,
  input  logic [DUR_W-1:0]      pulse_duration,
  input  logic                  frame_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     answer_byte,
  output logic                  decode_ok,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [REG_W-1:0]      bit_period;
  logic [REG_W-1:0]      mid_offset;
  logic [REG_W-1:0]      mid_tolerance;
  logic [GAP_W-1:0]      start_gap;

  logic                  req_level;
  logic [DUR_W-1:0]      req_duration;
  logic                  req_last;

  logic [TIME_W-1:0]     running_time;
  logic                  level_known;
  logic                  line_level;
  logic [EDGE_W-1:0]     edge_count;
  logic                  gap_found;
  logic [TIME_W-1:0]     previous_edge_time;
  logic [TIME_W-1:0]     window_start;
  logic [BP_W-1:0]       bit_position;
  dir_t                  mid_direction;
  dir_t                  edge_dir;
  logic [FRAME_BITS-1:0] decoded_bits;
  logic                  last_bit;
  logic [TIME_W:0]       mid_pos;

  logic [TIME_W:0]       window_end;
  logic [TIME_W:0]       time_sum;
  logic [TIME_W:0]       t_ext;
  logic [TIME_W:0]       mid_dist;
  logic [TIME_W-1:0]     gap;
  logic                  bits_left;
  logic                  close_bit;
  logic                  near_mid;
  logic                  restart;
  logic                  out_free;
  dir_t                  dir;
  logic [15:0]           bits_ext;
  logic [BYTE_W-1:0]     byte_val;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period    <= PERIOD_RST;
      mid_offset    <= OFFSET_RST;
      mid_tolerance <= TOL_RST;
      start_gap     <= GAP_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BIT_PERIOD:    bit_period    <= cfg_data[REG_W-1:0];
        CFG_MID_OFFSET:    mid_offset    <= cfg_data[REG_W-1:0];
        CFG_MID_TOLERANCE: mid_tolerance <= cfg_data[REG_W-1:0];
        CFG_START_GAP:     start_gap     <= cfg_data[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // combinational helpers
  always_comb begin
    t_ext      = {1'b0, running_time};
    window_end = {1'b0, window_start} + (TIME_W+1)'(bit_period);
    time_sum   = t_ext + (TIME_W+1)'(req_duration);
    gap        = running_time - previous_edge_time;
    bits_left  = bit_position < BP_W'(FRAME_BITS);
    restart    = (edge_count == '0) ||
                 (!gap_found && (gap > TIME_W'(start_gap)));
    mid_dist   = (t_ext >= mid_pos) ? (t_ext - mid_pos) : (mid_pos - t_ext);
    near_mid   = bits_left && (running_time >= window_start) &&
                 (mid_dist < (TIME_W+1)'(mid_tolerance));
    out_free   = !out_valid || out_ready;

    dir = DIR_NONE;
    if (level_known && line_level && !req_level) dir = DIR_FALL;
    else if (level_known && !line_level && req_level) dir = DIR_RISE;

    case (mid_direction)
      DIR_FALL: close_bit = 1'b1;
      DIR_RISE: close_bit = 1'b0;
      default:  close_bit = last_bit;
    endcase

    // bit i of the frame lands at byte bit 8 - i
    bits_ext = 16'(decoded_bits);
    for (int i = 1; i <= BYTE_W; i++) begin
      byte_val[BYTE_W-i] = bits_ext[i];
    end

    status.take_edge = (req_duration != '0) &&
                       (!level_known || (req_level != line_level)) &&
                       (edge_count < EDGE_W'(MAX_EDGES));
    status.can_close = bits_left && (window_end < t_ext);
    status.can_flush = bits_left;
    status.last      = req_last;
    status.frame_ok  = edge_count >= EDGE_W'(2);
    status.out_free  = out_free;
  end

  // window middle is registered and follows the window start in the next cycle
  always_ff @(posedge clk) begin
    mid_pos <= {1'b0, window_start} + (TIME_W+1)'(mid_offset);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_level    <= pulse_level;
      req_duration <= pulse_duration;
      req_last     <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.final_load) begin
      running_time       <= '0;
      level_known        <= 1'b0;
      line_level         <= 1'b0;
      edge_count         <= '0;
      gap_found          <= 1'b0;
      previous_edge_time <= '0;
      window_start       <= '0;
      bit_position       <= '0;
      mid_direction      <= DIR_NONE;
      edge_dir           <= DIR_NONE;
      decoded_bits       <= '0;
      last_bit           <= 1'b0;
    end else begin
      if (cmd.edge_start) begin
        edge_dir <= dir;
        if (restart) begin
          if (edge_count != '0) gap_found <= 1'b1;
          window_start  <= running_time;
          bit_position  <= '0;
          mid_direction <= DIR_NONE;
          decoded_bits  <= '0;
          last_bit      <= 1'b0;
        end
      end
      if (cmd.close_win || cmd.flush_win) begin
        decoded_bits[bit_position[IDX_W-1:0]] <= close_bit;
        last_bit      <= close_bit;
        bit_position  <= bit_position + BP_W'(1);
        mid_direction <= DIR_NONE;
        window_start  <= window_end[TIME_W] ? TIME_MAX : window_end[TIME_W-1:0];
      end
      if (cmd.mid_take) begin
        if (near_mid && (edge_dir != DIR_NONE)) mid_direction <= edge_dir;
        previous_edge_time <= running_time;
        line_level         <= req_level;
        level_known        <= 1'b1;
        edge_count         <= edge_count + EDGE_W'(1);
      end
      if (cmd.time_add) begin
        running_time <= time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.final_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.final_load) begin
      answer_byte <= status.frame_ok ? byte_val : FAIL_BYTE;
      decode_ok   <= status.frame_ok;
    end
  end

endmodule

// ===== hdl/dali_backward_frame_manchester_decoder.sv =====
// Decodes a DALI backward frame from line pulses given as level and duration
// in microseconds; one request at a time, in_ready only when idle. A pulse
// without an edge passes the idle, edge and time states; a pulse with an edge
// passes idle, edge, close, mid and time, closing windows one per cycle in
// the close state. A request with frame_end then loads the result register;
// when two or more edges were seen it first flushes the windows still open,
// one per cycle. The load waits while an earlier result is not yet taken;
// once loaded, the next request gets in while the result waits. Settings are
// to be written only while the block is idle; the block does not enforce it.
// cfg_ready is always high. Depends on dali_pkg, dali_ctrl and dali_dp.
module dali_backward_frame_manchester_decoder import dali_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  pulse_level,
  input  logic [DUR_W-1:0]      pulse_duration,
  input  logic                  frame_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     answer_byte,
  output logic                  decode_ok,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;
  state_t  state;

  dali_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  dali_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .pulse_level    (pulse_level),
    .pulse_duration (pulse_duration),
    .frame_end      (frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .answer_byte    (answer_byte),
    .decode_ok      (decode_ok),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

`ifndef SYNTHESIS
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.final_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_fail_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !decode_ok |-> answer_byte == FAIL_BYTE)
    else $error("failed decode without fail byte");

  a_final_state: assert property (@(posedge clk) disable iff (rst)
    cmd.final_load |=> state == ST_IDLE)
    else $error("result load did not return to idle");
`endif

endmodule
